FILE: src/bcgd_pkg.sv
package bcgd_pkg;

    // field widths
    localparam int KIND_W    = 3;
    localparam int BUTTON_W  = 3;
    localparam int TIME_W    = 32;
    localparam int GESTURE_W = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    // default number of buttons
    localparam int NUM_BUTTONS_DEF = 8;

    // register reset values
    localparam logic [CFG_W-1:0] HOLD_MS_RST   = 16'd500;
    localparam logic [CFG_W-1:0] DCLICK_MS_RST = 16'd300;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DCLICK_MS = 1'd1;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PRESS   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HELD    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POLL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd4;

    // gesture codes
    localparam logic [GESTURE_W-1:0] G_SINGLE = 2'd0;
    localparam logic [GESTURE_W-1:0] G_DOUBLE = 2'd1;
    localparam logic [GESTURE_W-1:0] G_HOLD   = 2'd2;

    // item travelling down the row of button cells
    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [BUTTON_W-1:0]  button;
        logic [TIME_W-1:0]    now_ms;
        logic                 hit;
        logic [BUTTON_W-1:0]  res_button;
        logic [GESTURE_W-1:0] res_gesture;
    } tok_t;

endpackage

FILE: src/bcgd_if.sv
interface bcgd_in_if;
    import bcgd_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BUTTON_W-1:0] button;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, kind, button, now_ms, input ready);
    modport sink   (input valid, kind, button, now_ms, output ready);
endinterface

interface bcgd_out_if;
    import bcgd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [BUTTON_W-1:0]  event_button;
    logic [GESTURE_W-1:0] gesture;

    modport source (output valid, event_button, gesture, input ready);
    modport sink   (input valid, event_button, gesture, output ready);
endinterface

FILE: src/bcgd_cell.sv
module bcgd_cell #(
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bcgd_pkg::CFG_W-1:0]   hold_ms,
    input  logic [bcgd_pkg::CFG_W-1:0]   dclick_ms,
    input  bcgd_pkg::tok_t               tok_in,
    output bcgd_pkg::tok_t               tok_out
);
    import bcgd_pkg::*;

    logic              down_reg, down_next;
    logic              hsent_reg, hsent_next;
    logic              single_reg, single_next;
    logic [TIME_W-1:0] press_reg, press_next;
    logic [TIME_W-1:0] rel_reg, rel_next;
    tok_t              tok_reg, tok_next;

    logic              mine;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_rel;
    logic              held_long;
    logic              in_window;

    // elapsed times, modulo 2^32
    assign mine        = (6'(tok_in.button) == 6'(IDX));
    assign since_press = tok_in.now_ms - press_reg;
    assign since_rel   = tok_in.now_ms - rel_reg;
    assign held_long   = (since_press >= {16'd0, hold_ms});
    assign in_window   = (since_rel <= {16'd0, dclick_ms});

    // per-button gesture update
    always_comb
    begin
        down_next   = down_reg;
        hsent_next  = hsent_reg;
        single_next = single_reg;
        press_next  = press_reg;
        rel_next    = rel_reg;
        tok_next    = tok_in;
        if (tok_in.valid)
        begin
            case (tok_in.kind)
                KIND_CLEAR:
                begin
                    down_next   = 1'b0;
                    hsent_next  = 1'b0;
                    single_next = 1'b0;
                    press_next  = '0;
                    rel_next    = '0;
                end
                KIND_POLL:
                begin
                    if (!tok_in.hit && single_reg && !in_window)
                    begin
                        single_next          = 1'b0;
                        tok_next.hit         = 1'b1;
                        tok_next.res_button  = 3'(IDX);
                        tok_next.res_gesture = G_SINGLE;
                    end
                end
                KIND_PRESS:
                begin
                    if (mine)
                    begin
                        down_next  = 1'b1;
                        hsent_next = 1'b0;
                        press_next = tok_in.now_ms;
                    end
                end
                KIND_HELD:
                begin
                    if (mine && down_reg && !hsent_reg && held_long)
                    begin
                        hsent_next           = 1'b1;
                        single_next          = 1'b0;
                        tok_next.hit         = 1'b1;
                        tok_next.res_button  = tok_in.button;
                        tok_next.res_gesture = G_HOLD;
                    end
                end
                KIND_RELEASE:
                begin
                    if (mine && down_reg)
                    begin
                        down_next = 1'b0;
                        if (hsent_reg)
                        begin
                            hsent_next  = 1'b0;
                            single_next = 1'b0;
                        end
                        else if (single_reg && in_window)
                        begin
                            single_next          = 1'b0;
                            tok_next.hit         = 1'b1;
                            tok_next.res_button  = tok_in.button;
                            tok_next.res_gesture = G_DOUBLE;
                        end
                        else
                        begin
                            single_next = 1'b1;
                            rel_next    = tok_in.now_ms;
                        end
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // button state, time stamps and item payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg   <= 1'b0;
            hsent_reg  <= 1'b0;
            single_reg <= 1'b0;
            press_reg  <= '0;
            rel_reg    <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            down_reg   <= down_next;
            hsent_reg  <= hsent_next;
            single_reg <= single_next;
            press_reg  <= press_next;
            rel_reg    <= rel_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: src/button_click_gesture_detector.sv
// Gesture detector for up to NUM_BUTTONS buttons: single click, double click, hold.
// events (sink): one item per press, held check, release, poll or clear-all,
//   each with a button number and a wrapping millisecond time stamp.
// gestures (source): zero or one item per input item, button and gesture code.
// cfg_we / cfg_index / cfg_data: write port for hold_ms (0) and double_click_ms (1),
//   to be written by the user only while idle; the block does not enforce it.
// Each item walks a row of NUM_BUTTONS cells, one cell per cycle, each cell
//   holding one button's state; poll claims the lowest expired button on the way.
// A result passes the cell row, the holding stage and then the output register.
// One item at a time: events.ready stays low until the item leaves the cell row
//   without a result, or until its result moves into the output register.
// A finished result sits in the output register while the next item is taken;
//   if the receiver stalls long enough, the following result waits in a
//   holding stage and events.ready stays low until it moves on.
// Reset clears all button state and loads hold_ms = 500, double_click_ms = 300.
module button_click_gesture_detector #(
    parameter int NUM_BUTTONS = bcgd_pkg::NUM_BUTTONS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bcgd_in_if.sink                        events,
    bcgd_out_if.source                     gestures,
    input  logic                           cfg_we,
    input  logic [bcgd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcgd_pkg::CFG_W-1:0]     cfg_data
);
    import bcgd_pkg::*;

    logic [CFG_W-1:0]     hold_ms_reg;
    logic [CFG_W-1:0]     dclick_ms_reg;
    logic                 busy_reg, busy_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [BUTTON_W-1:0]  pend_button_reg;
    logic [GESTURE_W-1:0] pend_gesture_reg;
    logic                 out_valid_reg, out_valid_next;
    logic [BUTTON_W-1:0]  out_button_reg;
    logic [GESTURE_W-1:0] out_gesture_reg;
    logic                 accept;
    logic                 out_load;
    tok_t                 chain [0:NUM_BUTTONS];
    tok_t                 tail;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg   <= HOLD_MS_RST;
            dclick_ms_reg <= DCLICK_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HOLD_MS:   hold_ms_reg   <= cfg_data;
                CFG_DCLICK_MS: dclick_ms_reg <= cfg_data;
                default:       hold_ms_reg   <= hold_ms_reg;
            endcase
        end
    end

    // launch into the first cell
    assign events.ready = !busy_reg;
    assign accept       = events.valid && !busy_reg;

    always_comb
    begin
        chain[0].valid       = accept;
        chain[0].kind        = events.kind;
        chain[0].button      = events.button;
        chain[0].now_ms      = events.now_ms;
        chain[0].hit         = 1'b0;
        chain[0].res_button  = '0;
        chain[0].res_gesture = G_SINGLE;
    end

    // row of button cells
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_cell
        bcgd_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .hold_ms   (hold_ms_reg),
            .dclick_ms (dclick_ms_reg),
            .tok_in    (chain[i]),
            .tok_out   (chain[i+1])
        );
    end

    assign tail     = chain[NUM_BUTTONS];
    assign out_load = pend_valid_reg && (!out_valid_reg || gestures.ready);

    // item tracking, holding stage and output register control
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if ((tail.valid && !tail.hit) || out_load)
            busy_next = 1'b0;

        pend_valid_next = pend_valid_reg;
        if (tail.valid && tail.hit)
            pend_valid_next = 1'b1;
        else if (out_load)
            pend_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (gestures.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (tail.valid && tail.hit)
        begin
            pend_button_reg  <= tail.res_button;
            pend_gesture_reg <= tail.res_gesture;
        end
        if (out_load)
        begin
            out_button_reg  <= pend_button_reg;
            out_gesture_reg <= pend_gesture_reg;
        end
    end

    assign gestures.valid        = out_valid_reg;
    assign gestures.event_button = out_button_reg;
    assign gestures.gesture      = out_gesture_reg;

endmodule

FILE: src/bcgd_checker.sv
module bcgd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [bcgd_pkg::BUTTON_W-1:0]    out_button,
    input logic [bcgd_pkg::GESTURE_W-1:0]   out_gesture
);
    import bcgd_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_button) && $stable(out_gesture))
        else $error("result payload changed while stalled");

    // one item at a time: no second item right after an accepted one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item in flight");

    // a result never appears the cycle after an item is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result shown too early");

    // only defined gesture codes leave the block
    a_gesture_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_gesture == G_SINGLE || out_gesture == G_DOUBLE ||
                       out_gesture == G_HOLD))
        else $error("undefined gesture code");

endmodule

bind button_click_gesture_detector bcgd_checker u_bcgd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (events.valid),
    .in_ready    (events.ready),
    .out_valid   (gestures.valid),
    .out_ready   (gestures.ready),
    .out_button  (gestures.event_button),
    .out_gesture (gestures.gesture)
);
